// ===== hw/rtl/cpts_pkg.sv =====
// ----------------------------------------------------------------------------
// cpts_pkg
// Types and constants shared by the counter/priority task scheduler and its
// chain of task cells.
// ----------------------------------------------------------------------------
`default_nettype none

package cpts_pkg;

	localparam int unsigned COUNT_W   = 11;
	localparam int unsigned PRIO_W    = 8;
	localparam int unsigned DEPTH_W   = 4;
	localparam int unsigned SLOT_W    = 4;
	localparam int unsigned CUR_W     = 4;
	localparam int unsigned MASK_W    = 16;
	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned OUT_DATA_W = 24;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 4'd15;

	typedef enum logic [2:0] {
		OP_TICK        = 3'd0,
		OP_YIELD       = 3'd1,
		OP_EXIT        = 3'd2,
		OP_REAP        = 3'd3,
		OP_PREEMPT_OFF = 3'd4,
		OP_PREEMPT_ON  = 3'd5,
		OP_ADD         = 3'd6,
		OP_NOP         = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		logic              apply;
		logic              recount;
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [PRIO_W-1:0] prio;
	} cell_cmd_t;

	// Best candidate so far, handed from one cell to the next.
	typedef struct packed {
		logic               found;
		logic [COUNT_W-1:0] top;
	} cand_t;

	// Status that each cell reports back to the sequencer.
	typedef struct packed {
		logic tick_sel;
		logic reap;
	} cell_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cpts_cell.sv =====
// ----------------------------------------------------------------------------
// cpts_cell
// One task slot: holds its state, applies broadcast events and recounts, and
// passes the running best candidate on to the next cell each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_cell #(
	parameter int unsigned IW  = 4,
	parameter int unsigned IDX = 0
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire cpts_pkg::cell_cmd_t   cmd,
	input  wire  [IW-1:0]              cur,
	input  wire cpts_pkg::cand_t       cand_in,
	input  wire  [IW-1:0]              pick_in,
	output cpts_pkg::cand_t            cand_out,
	output logic [IW-1:0]              pick_out,
	output cpts_pkg::cell_stat_t       stat
);

	logic                           valid_q;
	logic                           zombie_q;
	logic [cpts_pkg::COUNT_W-1:0]   count_q;
	logic [cpts_pkg::PRIO_W-1:0]    prio_q;
	logic [cpts_pkg::DEPTH_W-1:0]   depth_q;
	cpts_pkg::cand_t                cand_q;
	logic [IW-1:0]                  pick_q;

	logic                           is_cur;
	logic                           is_add;
	logic [IW+3:0]                  slot_ext;
	logic [cpts_pkg::COUNT_W:0]     recount_sum;
	logic                           runnable;

	assign slot_ext    = {{IW{1'b0}}, cmd.slot};
	assign is_cur      = (cur == IW'(IDX));
	assign is_add      = (slot_ext == (IW + 4)'(IDX));
	assign recount_sum = {2'b00, count_q[cpts_pkg::COUNT_W-1:1]}
		+ {{(cpts_pkg::COUNT_W + 1 - cpts_pkg::PRIO_W){1'b0}}, prio_q};
	assign runnable    = valid_q && !zombie_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= (IDX == 0);
			zombie_q <= 1'b0;
			count_q  <= '0;
			prio_q   <= (IDX == 0) ? cpts_pkg::PRIO_W'(1) : '0;
			depth_q  <= '0;
		end else if (cmd.apply) begin
			unique case (cmd.op)
				cpts_pkg::OP_TICK: begin
					if (is_cur && count_q != '0) begin
						count_q <= count_q - 1'b1;
					end
				end
				cpts_pkg::OP_YIELD: begin
					if (is_cur) begin
						count_q <= '0;
					end
				end
				cpts_pkg::OP_EXIT: begin
					if (is_cur) begin
						zombie_q <= 1'b1;
						count_q  <= '0;
					end
				end
				cpts_pkg::OP_REAP: begin
					if (valid_q && zombie_q) begin
						valid_q  <= 1'b0;
						zombie_q <= 1'b0;
					end
				end
				cpts_pkg::OP_PREEMPT_OFF: begin
					if (is_cur && depth_q != cpts_pkg::DEPTH_MAX) begin
						depth_q <= depth_q + 1'b1;
					end
				end
				cpts_pkg::OP_PREEMPT_ON: begin
					if (is_cur && depth_q != '0) begin
						depth_q <= depth_q - 1'b1;
					end
				end
				cpts_pkg::OP_ADD: begin
					if (is_add) begin
						valid_q  <= 1'b1;
						zombie_q <= 1'b0;
						count_q  <= {{(cpts_pkg::COUNT_W - cpts_pkg::PRIO_W){1'b0}}, cmd.prio};
						prio_q   <= cmd.prio;
						depth_q  <= '0;
					end
				end
				cpts_pkg::OP_NOP: begin
				end
				default: begin
				end
			endcase
		end else if (cmd.recount && valid_q) begin
			if (recount_sum > {1'b0, cpts_pkg::COUNT_MAX}) begin
				count_q <= cpts_pkg::COUNT_MAX;
			end else begin
				count_q <= recount_sum[cpts_pkg::COUNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
			pick_q <= '0;
		end else if (runnable && (!cand_in.found || count_q > cand_in.top)) begin
			cand_q.found <= 1'b1;
			cand_q.top   <= count_q;
			pick_q       <= IW'(IDX);
		end else begin
			cand_q <= cand_in;
			pick_q <= pick_in;
		end
	end

	assign cand_out      = cand_q;
	assign pick_out      = pick_q;
	assign stat.tick_sel = is_cur && (count_q <= cpts_pkg::COUNT_W'(1)) && (depth_q == '0);
	assign stat.reap     = valid_q && zombie_q;

endmodule

`default_nettype wire

// ===== hw/rtl/counter_priority_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler
// Counter/priority task scheduler built as a chain of task-slot cells.
// ----------------------------------------------------------------------------
// Events arrive on the s_axis channel, one per transaction: s_tdata holds
// op, slot and prio. Each event gives exactly one result transaction on the
// m_axis channel with the running slot, the switched flag, the mask of slots
// reaped and the no-runnable flag.
// Selection runs the best candidate down the row of TASKS cells, one cell
// per cycle. An event that needs no selection goes from EXEC to FINISH; one
// with a selection passes through EXEC, SCAN and DECIDE, and one that also
// recounts runs SCAN and DECIDE a second time before FINISH. One event is in
// progress at a time; s_tready is high only while the sequencer is idle.
// Reset puts slot 0 in place as the only valid task, with priority one, and
// makes it the running slot. A stalled receiver holds the result in the
// output register; the block can take and work on the next event meanwhile,
// and waits only before presenting its result.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_priority_task_scheduler #(
	parameter int unsigned TASKS = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [cpts_pkg::IN_DATA_W-1:0]      s_tdata,  // op[2:0], slot[6:3], prio[14:7]
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [cpts_pkg::OUT_DATA_W-1:0]     m_tdata   // current_task[3:0], switched[4],
	                                                      // reaped_mask[20:5], none_runnable[21]
);

	localparam int unsigned IW = (TASKS > 1) ? $clog2(TASKS) : 1;

	cpts_pkg::state_t      state_q, state_d;
	cpts_pkg::op_t         op_q;
	logic [cpts_pkg::SLOT_W-1:0] slot_q;
	logic [cpts_pkg::PRIO_W-1:0] prio_q;
	logic [IW-1:0]         running_q;
	logic [IW-1:0]         start_q;
	logic [IW-1:0]         scan_cnt_q;
	logic                  recounted_q;
	logic                  none_q;
	logic [cpts_pkg::MASK_W-1:0] reaped_q;
	logic                  m_tvalid_q;
	logic [cpts_pkg::OUT_DATA_W-1:0] m_tdata_q;

	cpts_pkg::cell_cmd_t   cmd;
	cpts_pkg::cand_t       cand [TASKS+1];
	logic [IW-1:0]         pick [TASKS+1];
	cpts_pkg::cell_stat_t  stat [TASKS];
	logic [TASKS-1:0]      tick_sel_v;
	logic [TASKS-1:0]      reap_v;
	logic [cpts_pkg::MASK_W-1:0] reap_mask;

	logic                  accept;
	logic                  out_free;
	logic                  need_sel;
	logic                  need_recount;
	logic                  scan_last;
	logic [IW+3:0]         run_ext;

	assign cand[0] = '0;
	assign pick[0] = '0;

	for (genvar i = 0; i < TASKS; i++) begin : g_cell
		cpts_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.cur      (running_q),
			.cand_in  (cand[i]),
			.pick_in  (pick[i]),
			.cand_out (cand[i+1]),
			.pick_out (pick[i+1]),
			.stat     (stat[i])
		);
		assign tick_sel_v[i] = stat[i].tick_sel;
		assign reap_v[i]     = stat[i].reap;
	end

	for (genvar b = 0; b < cpts_pkg::MASK_W; b++) begin : g_mask
		if (b < TASKS) begin : g_on
			assign reap_mask[b] = reap_v[b];
		end else begin : g_off
			assign reap_mask[b] = 1'b0;
		end
	end

	assign accept       = s_tvalid && s_tready;
	assign out_free     = !m_tvalid_q || m_tready;
	assign scan_last    = (scan_cnt_q == IW'(TASKS - 1));
	assign need_recount = cand[TASKS].found && (cand[TASKS].top == '0) && !recounted_q;
	assign run_ext      = {4'b0000, running_q};

	always_comb begin
		unique case (op_q)
			cpts_pkg::OP_TICK:  need_sel = |tick_sel_v;
			cpts_pkg::OP_YIELD: need_sel = 1'b1;
			cpts_pkg::OP_EXIT:  need_sel = 1'b1;
			default:            need_sel = 1'b0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpts_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = cpts_pkg::ST_EXEC;
				end
			end
			cpts_pkg::ST_EXEC: begin
				state_d = need_sel ? cpts_pkg::ST_SCAN : cpts_pkg::ST_FINISH;
			end
			cpts_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = cpts_pkg::ST_DECIDE;
				end
			end
			cpts_pkg::ST_DECIDE: begin
				state_d = need_recount ? cpts_pkg::ST_SCAN : cpts_pkg::ST_FINISH;
			end
			cpts_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = cpts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cpts_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready    = (state_q == cpts_pkg::ST_IDLE);
		cmd.apply   = (state_q == cpts_pkg::ST_EXEC);
		cmd.recount = (state_q == cpts_pkg::ST_DECIDE) && need_recount;
		cmd.op      = op_q;
		cmd.slot    = slot_q;
		cmd.prio    = prio_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpts_pkg::ST_IDLE;
			op_q        <= cpts_pkg::OP_NOP;
			running_q   <= '0;
			start_q     <= '0;
			scan_cnt_q  <= '0;
			recounted_q <= 1'b0;
			none_q      <= 1'b0;
			reaped_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				cpts_pkg::ST_IDLE: begin
					if (accept) begin
						op_q    <= cpts_pkg::op_t'(s_tdata[2:0]);
						start_q <= running_q;
					end
				end
				cpts_pkg::ST_EXEC: begin
					scan_cnt_q  <= '0;
					recounted_q <= 1'b0;
					none_q      <= 1'b0;
					reaped_q    <= (op_q == cpts_pkg::OP_REAP) ? reap_mask : '0;
				end
				cpts_pkg::ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
				end
				cpts_pkg::ST_DECIDE: begin
					scan_cnt_q <= '0;
					if (need_recount) begin
						recounted_q <= 1'b1;
					end else if (cand[TASKS].found) begin
						running_q <= pick[TASKS];
					end else begin
						running_q <= '0;
						none_q    <= 1'b1;
					end
				end
				cpts_pkg::ST_FINISH: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= s_tdata[6:3];
			prio_q <= s_tdata[14:7];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == cpts_pkg::ST_FINISH && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cpts_pkg::ST_FINISH && out_free) begin
			m_tdata_q <= {2'b00, none_q, reaped_q, (running_q != start_q), run_ext[3:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cpts_checker.sv =====
// ----------------------------------------------------------------------------
// cpts_checker
// Port-level checks for the counter/priority task scheduler, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_tvalid,
	input wire                              s_tready,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [cpts_pkg::OUT_DATA_W-1:0]   m_tdata
);

	// A result that is not taken stays in place unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// One event at a time: after a transaction the input side closes.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an event is in progress");

	// A reap makes no selection, so it reports neither a switch nor an empty table.
	a_reap_no_select: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[20:5] != 16'd0) |-> !m_tdata[4] && !m_tdata[21])
		else $error("reap reported a selection");

	// With nothing runnable, slot 0 is chosen.
	a_none_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[21] |-> m_tdata[3:0] == 4'd0)
		else $error("no runnable task but slot 0 not chosen");

	// Padding bits stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:22] == 2'b00)
		else $error("padding bits set");

endmodule

bind counter_priority_task_scheduler cpts_checker u_cpts_checker (.*);

`default_nettype wire

// ===== tb/tb_counter_priority_task_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counter_priority_task_scheduler
// Self-checking testbench for the counter/priority task scheduler.
// ----------------------------------------------------------------------------
// Scheduling events are sent on the input stream and each one is predicted
// on a private copy of the task table. Every result transaction is checked
// field by field against the oldest prediction. A short directed sequence is
// followed by random events under several patterns of source idling and
// sink back-pressure, one of them with a long hold-off on the sink.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic        none_runnable;
	logic [15:0] reaped_mask;
	logic        switched;
	logic [3:0]  current_task;
} sched_pick_t;

class sched_scoreboard;
	localparam int TASKS = 16;

	bit          valid[TASKS];
	bit          zombie[TASKS];
	logic [10:0] slice[TASKS];
	logic [7:0]  prio[TASKS];
	logic [3:0]  depth[TASKS];
	logic [3:0]  running;
	sched_pick_t expected_picks[$];
	int unsigned errors;

	function new();
		for (int i = 0; i < TASKS; i++) begin
			valid[i]  = 1'b0;
			zombie[i] = 1'b0;
			slice[i]  = '0;
			prio[i]   = '0;
			depth[i]  = '0;
		end
		valid[0] = 1'b1;
		prio[0]  = 8'd1;
		running  = '0;
		errors   = 0;
	endfunction

	function int find_busiest(output logic [10:0] best);
		int pick;
		pick = -1;
		best = '0;
		for (int i = 0; i < TASKS; i++) begin
			if (valid[i] && !zombie[i] && (pick < 0 || slice[i] > best)) begin
				best = slice[i];
				pick = i;
			end
		end
		return pick;
	endfunction

	// Returns one when no task could run and slot 0 was taken instead.
	function bit pick_next();
		int          pick;
		logic [10:0] best;
		int unsigned recount;
		pick = find_busiest(best);
		if (pick >= 0 && best == 0) begin
			for (int i = 0; i < TASKS; i++) begin
				if (valid[i]) begin
					recount  = (slice[i] >> 1) + prio[i];
					slice[i] = (recount > 2047) ? 11'd2047 : recount[10:0];
				end
			end
			pick = find_busiest(best);
		end
		if (pick < 0) begin
			running = '0;
			return 1'b1;
		end
		running = pick[3:0];
		return 1'b0;
	endfunction

	function void note_event(cpts_pkg::op_t op, logic [3:0] slot, logic [7:0] p);
		logic [3:0]  cur;
		sched_pick_t res;
		cur = running;
		res = '0;
		case (op)
			cpts_pkg::OP_TICK: begin
				if (slice[cur] > 0)
					slice[cur] = slice[cur] - 1'b1;
				if (slice[cur] == 0 && depth[cur] == 0)
					res.none_runnable = pick_next();
			end
			cpts_pkg::OP_YIELD: begin
				slice[cur] = '0;
				res.none_runnable = pick_next();
			end
			cpts_pkg::OP_EXIT: begin
				zombie[cur] = 1'b1;
				slice[cur]  = '0;
				res.none_runnable = pick_next();
			end
			cpts_pkg::OP_REAP: begin
				for (int i = 0; i < TASKS; i++) begin
					if (valid[i] && zombie[i]) begin
						valid[i]  = 1'b0;
						zombie[i] = 1'b0;
						res.reaped_mask[i] = 1'b1;
					end
				end
			end
			cpts_pkg::OP_PREEMPT_OFF: begin
				if (depth[cur] < cpts_pkg::DEPTH_MAX)
					depth[cur] = depth[cur] + 1'b1;
			end
			cpts_pkg::OP_PREEMPT_ON: begin
				if (depth[cur] > 0)
					depth[cur] = depth[cur] - 1'b1;
			end
			cpts_pkg::OP_ADD: begin
				valid[slot]  = 1'b1;
				zombie[slot] = 1'b0;
				slice[slot]  = {3'b000, p};
				prio[slot]   = p;
				depth[slot]  = '0;
			end
			default: begin
			end
		endcase
		res.current_task = running;
		res.switched     = (running != cur);
		expected_picks.push_back(res);
	endfunction

	function void check_pick(logic [23:0] data);
		sched_pick_t exp_pick;
		if (expected_picks.size() == 0) begin
			$display("%0t: result with nothing expected, actual %h", $time, data);
			errors++;
			return;
		end
		exp_pick = expected_picks.pop_front();
		if (data[3:0] !== exp_pick.current_task) begin
			$display("%0t: current_task expected %0d actual %0d", $time,
				exp_pick.current_task, data[3:0]);
			errors++;
		end
		if (data[4] !== exp_pick.switched) begin
			$display("%0t: switched expected %0b actual %0b", $time,
				exp_pick.switched, data[4]);
			errors++;
		end
		if (data[20:5] !== exp_pick.reaped_mask) begin
			$display("%0t: reaped_mask expected %h actual %h", $time,
				exp_pick.reaped_mask, data[20:5]);
			errors++;
		end
		if (data[21] !== exp_pick.none_runnable) begin
			$display("%0t: none_runnable expected %0b actual %0b", $time,
				exp_pick.none_runnable, data[21]);
			errors++;
		end
	endfunction
endclass

module tb_counter_priority_task_scheduler;

	localparam int TASKS         = 16;
	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_OFF      = 600;
	localparam int SETTLE_CYCLES = 2 * TASKS + 20;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // op[2:0], slot[6:3], prio[14:7]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // current_task[3:0], switched[4],
	                             // reaped_mask[20:5], none_runnable[21]

	sched_scoreboard sb = new();
	int unsigned     send_idle_pct = 0;
	int unsigned     recv_stall_pct = 0;
	logic            hold_off = 1'b0;
	int unsigned     quiet_cycles = 0;

	counter_priority_task_scheduler #(
		.TASKS(TASKS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_pick(m_tdata);
		m_tready <= hold_off ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic offer_event(input cpts_pkg::op_t op, input logic [3:0] slot,
		input logic [7:0] p);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, p, slot, op};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_event(op, slot, p);
	endtask

	task automatic send_random_events(input int unsigned n);
		int unsigned sent;
		int unsigned r;
		logic [7:0]  p;
		logic [3:0]  slot;
		sent = 0;
		while (sent < n) begin
			r    = $urandom_range(99);
			p    = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
			slot = 4'($urandom_range(15));
			if (r < 35)
				offer_event(cpts_pkg::OP_TICK, slot, p);
			else if (r < 55)
				offer_event(cpts_pkg::OP_ADD, slot, p);
			else if (r < 65)
				offer_event(cpts_pkg::OP_YIELD, slot, p);
			else if (r < 72)
				offer_event(cpts_pkg::OP_EXIT, slot, p);
			else if (r < 79)
				offer_event(cpts_pkg::OP_REAP, slot, p);
			else if (r < 87)
				offer_event(cpts_pkg::OP_PREEMPT_OFF, slot, p);
			else if (r < 96)
				offer_event(cpts_pkg::OP_PREEMPT_ON, slot, p);
			else if (r < 99)
				offer_event(cpts_pkg::OP_NOP, slot, p);
			else begin
				// Drive the preemption depth into both of its limits.
				repeat (17) offer_event(cpts_pkg::OP_PREEMPT_OFF, 4'($urandom_range(15)), p);
				repeat (2) offer_event(cpts_pkg::OP_TICK, 4'($urandom_range(15)), p);
				repeat (17) offer_event(cpts_pkg::OP_PREEMPT_ON, 4'($urandom_range(15)), p);
				sent += 35;
			end
			sent++;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_event(cpts_pkg::OP_TICK, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_ADD, 4'd15, 8'd255);
		offer_event(cpts_pkg::OP_ADD, 4'd1, 8'd0);
		offer_event(cpts_pkg::OP_TICK, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_PREEMPT_OFF, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_TICK, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_YIELD, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_PREEMPT_ON, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_EXIT, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_REAP, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_REAP, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_EXIT, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_EXIT, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_TICK, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_REAP, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_TICK, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_YIELD, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_PREEMPT_ON, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_ADD, 4'd0, 8'h80);
		offer_event(cpts_pkg::OP_ADD, 4'd7, 8'h7F);
		offer_event(cpts_pkg::OP_NOP, 4'd15, 8'd255);
		offer_event(cpts_pkg::OP_YIELD, 4'd0, 8'd0);
		offer_event(cpts_pkg::OP_ADD, 4'd7, 8'd3);
		offer_event(cpts_pkg::OP_YIELD, 4'd0, 8'd0);

		// The sink holds off for a long stretch while events keep coming.
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLD_OFF) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		send_random_events(470);

		send_idle_pct = 83;
		send_random_events(470);

		send_idle_pct = 0;
		recv_stall_pct <= 83;
		send_random_events(470);

		send_idle_pct = 27;
		recv_stall_pct <= 27;
		send_random_events(470);

		s_tvalid <= 1'b0;
		while (sb.expected_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.expected_picks.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.expected_picks.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/cpts_pkg.sv
hw/rtl/cpts_cell.sv
hw/rtl/counter_priority_task_scheduler.sv
hw/rtl/cpts_checker.sv
tb/tb_counter_priority_task_scheduler.sv
